// File: rtl/binomial_tree_futures_option_assert.svh
// Assertion macros used by the checker file of the option pricer.
`ifndef BINOMIAL_TREE_FUTURES_OPTION_ASSERT_SVH
`define BINOMIAL_TREE_FUTURES_OPTION_ASSERT_SVH

// Implication whose consequent is checked in the next cycle, ignored while reset is high.
`define BTFO_CHK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");

// Condition that must hold in the cycle after reset.
`define BTFO_CHK_RST(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("reset check failed");

`endif

// File: rtl/btfo_pkg.sv
// Shared types and constants of the binomial tree futures option pricer.
`default_nettype none
package btfo_pkg;
   localparam int MAX_STEPS_DEF   = 256;
   localparam int PRICE_WIDTH_DEF = 32;
   localparam int CSR_IDX_W       = 3;

   localparam logic [CSR_IDX_W-1:0] REG_UP_FACTOR     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DOWN_FACTOR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UP_PROB       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DISCOUNT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_COUNT    = 3'd4;

   localparam logic [31:0] UP_RESET       = 32'd1073741824;
   localparam logic [30:0] DOWN_RESET     = 31'd1073741824;
   localparam logic [31:0] PROB_RESET     = 32'd1073741824;
   localparam logic [31:0] DISC_RESET     = 32'd2147483648;
   localparam logic [8:0]  STEP_RESET     = 9'd1;
   localparam logic [31:0] PROB_ONE       = 32'd2147483648;

   typedef enum logic [3:0] {
      ST_IDLE, ST_GPROD, ST_GSHIFT, ST_LSHIFT, ST_UPROD, ST_UUPD,
      ST_PAY, ST_IPROD, ST_IUPD, ST_DPROD, ST_DSAT
   } state_type;

   typedef enum logic [2:0] {
      OP_HOLD, OP_SHIFT, OP_UPROD, OP_UUPD, OP_PAY, OP_IPROD, OP_IUPD
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        is_put;
      logic [31:0] fa;
      logic [31:0] fb;
   } cell_ctl_type;
endpackage
`default_nettype wire

// File: rtl/btfo_cell.sv
// One tree node cell: holds a node value, forms leaves and backward induction steps.
`default_nettype none
module btfo_cell #(
   parameter int P   = btfo_pkg::PRICE_WIDTH_DEF,
   parameter int CW  = 9,
   parameter int IDX = 0
) (
   input  wire                   clock,
   input  wire btfo_pkg::cell_ctl_type ctl,
   input  wire  [CW-1:0]         cnt,
   input  wire  [CW-1:0]         limit,
   input  wire  [P-1:0]          strike,
   input  wire  [P-1:0]          left_v,
   input  wire                   left_f,
   input  wire  [P-1:0]          right_v,
   input  wire                   right_f,
   output logic [P-1:0]          v,
   output logic                  f
);
   localparam int PW = P + 32;
   localparam logic [CW-1:0] MY_IDX = CW'(IDX);

   logic [P-1:0]  v_ff, v_in;
   logic          f_ff, f_in;
   logic [PW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [PW-1:0] ua_sh, ia_sh, ib_sh;
   logic          ua_ovf, ia_ovf, ib_ovf, sum_ovf;
   logic [P-1:0]  ua, ia, ib;
   logic [P:0]    sum;

   always_comb begin
      ua_sh   = pa_ff >> 30;
      ua_ovf  = |pa_ff[PW-1:P+30];
      ua      = ua_ovf ? '1 : ua_sh[P-1:0];
      ia_sh   = pb_ff >> 31;
      ia_ovf  = |pb_ff[PW-1:P+31];
      ia      = ia_ovf ? '1 : ia_sh[P-1:0];
      ib_sh   = pa_ff >> 31;
      ib_ovf  = |pa_ff[PW-1:P+31];
      ib      = ib_ovf ? '1 : ib_sh[P-1:0];
      sum     = {1'b0, ia} + {1'b0, ib};
      sum_ovf = sum[P];
   end

   always_comb begin
      v_in  = v_ff;
      f_in  = f_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      case (ctl.op)
         btfo_pkg::OP_SHIFT: begin
            v_in = left_v;
            f_in = left_f;
         end
         btfo_pkg::OP_UPROD: begin
            pa_in = PW'(v_ff) * PW'(ctl.fa);
         end
         btfo_pkg::OP_UUPD: begin
            if (cnt < MY_IDX && !f_ff) begin
               v_in = ua;
               f_in = ua_ovf;
            end
         end
         btfo_pkg::OP_PAY: begin
            if (ctl.is_put) begin
               v_in = (strike > v_ff) ? strike - v_ff : '0;
            end else begin
               v_in = (v_ff > strike) ? v_ff - strike : '0;
            end
         end
         btfo_pkg::OP_IPROD: begin
            pa_in = PW'(v_ff) * PW'(ctl.fb);
            pb_in = PW'(right_v) * PW'(ctl.fa);
         end
         btfo_pkg::OP_IUPD: begin
            if (MY_IDX < limit) begin
               v_in = sum_ovf ? '1 : sum[P-1:0];
               f_in = f_ff | right_f | ia_ovf | ib_ovf | sum_ovf;
            end
         end
         default: begin
            v_in = v_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      v_ff  <= v_in;
      f_ff  <= f_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
   end

   assign v = v_ff;
   assign f = f_ff;
endmodule
`default_nettype wire

// File: rtl/binomial_tree_futures_option.sv
// Top level of the binomial tree futures option pricer with its row of node cells.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_ready  | future_price, strike_price, is_put
//   rsp     | out       | rsp_valid/rsp_ready  | option_price, overflow
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// One item for N tree steps runs in order: building and shifting in the down-move
// spot chain, the up moves in all cells at once, the payoff, the induction levels
// and the discount of the root, each step being a multiply followed by an update.
// Items are taken one at a time; reset is synchronous and leaves
// the block idle with no result pending. A waiting result holds the last stage.
`default_nettype none
module binomial_tree_futures_option #(
   parameter int MAX_STEPS   = btfo_pkg::MAX_STEPS_DEF,
   parameter int PRICE_WIDTH = btfo_pkg::PRICE_WIDTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_future_price,
   input  wire  [31:0] req_strike_price,
   input  wire         req_is_put,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_option_price,
   output logic        rsp_overflow,
   input  wire         csr_we,
   input  wire  [btfo_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [31:0] csr_wdata
);
   localparam int P  = PRICE_WIDTH;
   localparam int PW = P + 32;
   localparam int CW = $clog2(MAX_STEPS + 1);

   btfo_pkg::state_type state_ff, state_in;
   btfo_pkg::cell_ctl_type ctl;

   logic [31:0] up_ff, prob_ff, disc_ff;
   logic [30:0] down_ff;
   logic [8:0]  step_ff;

   logic [CW-1:0] n_ff, n_in, cnt_ff, cnt_in, limit;
   logic [P-1:0]  strike_ff, strike_in, dval_ff, dval_in;
   logic          put_ff, put_in, dsat_ff, dsat_in, ovf_ff, ovf_in;
   logic [PW-1:0] dprod_ff, dprod_in, fut_w, strike_w, dsh, dprod_sh;
   logic [31:0]   p_eff, q_eff, out_price_ff, out_price_in;
   logic          out_valid_ff, out_valid_in, out_ovf_ff, out_ovf_in;
   logic          accept, out_free, last_cnt, dsat_new, disc_sat;

   logic [P-1:0] cv [0:MAX_STEPS+1];
   logic         cf [0:MAX_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff   <= btfo_pkg::UP_RESET;
         down_ff <= btfo_pkg::DOWN_RESET;
         prob_ff <= btfo_pkg::PROB_RESET;
         disc_ff <= btfo_pkg::DISC_RESET;
         step_ff <= btfo_pkg::STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            btfo_pkg::REG_UP_FACTOR:   up_ff   <= csr_wdata;
            btfo_pkg::REG_DOWN_FACTOR: down_ff <= csr_wdata[30:0];
            btfo_pkg::REG_UP_PROB:     prob_ff <= csr_wdata;
            btfo_pkg::REG_DISCOUNT:    disc_ff <= csr_wdata;
            btfo_pkg::REG_STEP_COUNT:  step_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign accept   = req_valid && req_ready;
   assign out_free = !out_valid_ff || rsp_ready;
   assign last_cnt = (cnt_ff + CW'(1)) == n_ff;
   assign limit    = n_ff - cnt_ff;
   assign p_eff    = (prob_ff > btfo_pkg::PROB_ONE) ? btfo_pkg::PROB_ONE : prob_ff;
   assign q_eff    = btfo_pkg::PROB_ONE - p_eff;
   assign fut_w    = PW'(req_future_price);
   assign strike_w = PW'(req_strike_price);
   assign dsh      = dprod_ff >> 30;
   assign dsat_new = |dprod_ff[PW-1:P+30];
   assign dprod_sh = dprod_ff >> 31;
   assign disc_sat = |dprod_sh[PW-1:32];

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      strike_in    = strike_ff;
      put_in       = put_ff;
      dval_in      = dval_ff;
      dsat_in      = dsat_ff;
      dprod_in     = dprod_ff;
      ovf_in       = ovf_ff;
      out_price_in = out_price_ff;
      out_ovf_in   = out_ovf_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      ctl.op       = btfo_pkg::OP_HOLD;
      ctl.is_put   = put_ff;
      ctl.fa       = p_eff;
      ctl.fb       = q_eff;
      case (state_ff)
         btfo_pkg::ST_IDLE: begin
            if (accept) begin
               if (32'(step_ff) > 32'(MAX_STEPS)) begin
                  n_in = CW'(MAX_STEPS);
               end else if (step_ff == 9'd0) begin
                  n_in = CW'(1);
               end else begin
                  n_in = CW'(step_ff);
               end
               dval_in   = (|(fut_w >> P)) ? '1 : fut_w[P-1:0];
               strike_in = (|(strike_w >> P)) ? '1 : strike_w[P-1:0];
               ovf_in    = (|(fut_w >> P)) || (|(strike_w >> P));
               put_in    = req_is_put;
               dsat_in   = 1'b0;
               cnt_in    = '0;
               state_in  = btfo_pkg::ST_GPROD;
            end
         end
         btfo_pkg::ST_GPROD: begin
            dprod_in = PW'(dval_ff) * PW'(down_ff);
            state_in = btfo_pkg::ST_GSHIFT;
         end
         btfo_pkg::ST_GSHIFT: begin
            ctl.op = btfo_pkg::OP_SHIFT;
            if (!dsat_ff) begin
               dval_in = dsat_new ? '1 : dsh[P-1:0];
               dsat_in = dsat_new;
            end
            cnt_in   = cnt_ff + CW'(1);
            state_in = last_cnt ? btfo_pkg::ST_LSHIFT : btfo_pkg::ST_GPROD;
         end
         btfo_pkg::ST_LSHIFT: begin
            ctl.op   = btfo_pkg::OP_SHIFT;
            cnt_in   = '0;
            state_in = btfo_pkg::ST_UPROD;
         end
         btfo_pkg::ST_UPROD: begin
            ctl.op   = btfo_pkg::OP_UPROD;
            ctl.fa   = up_ff;
            state_in = btfo_pkg::ST_UUPD;
         end
         btfo_pkg::ST_UUPD: begin
            ctl.op = btfo_pkg::OP_UUPD;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = btfo_pkg::ST_PAY;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = btfo_pkg::ST_UPROD;
            end
         end
         btfo_pkg::ST_PAY: begin
            ctl.op   = btfo_pkg::OP_PAY;
            state_in = btfo_pkg::ST_IPROD;
         end
         btfo_pkg::ST_IPROD: begin
            ctl.op   = btfo_pkg::OP_IPROD;
            state_in = btfo_pkg::ST_IUPD;
         end
         btfo_pkg::ST_IUPD: begin
            ctl.op = btfo_pkg::OP_IUPD;
            if (last_cnt) begin
               state_in = btfo_pkg::ST_DPROD;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = btfo_pkg::ST_IPROD;
            end
         end
         btfo_pkg::ST_DPROD: begin
            dprod_in = PW'(cv[0]) * PW'(disc_ff);
            state_in = btfo_pkg::ST_DSAT;
         end
         btfo_pkg::ST_DSAT: begin
            if (out_free) begin
               out_price_in = disc_sat ? '1 : dprod_sh[31:0];
               out_ovf_in   = ovf_ff | cf[0] | disc_sat;
               out_valid_in = 1'b1;
               state_in     = btfo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = btfo_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btfo_pkg::ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      strike_ff    <= strike_in;
      put_ff       <= put_in;
      dval_ff      <= dval_in;
      dsat_ff      <= dsat_in;
      dprod_ff     <= dprod_in;
      ovf_ff       <= ovf_in;
      out_price_ff <= out_price_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign cv[MAX_STEPS+1] = '0;
   assign cf[MAX_STEPS+1] = 1'b0;

   for (genvar k = 0; k <= MAX_STEPS; k++) begin : g_cell
      btfo_cell #(
         .P   (P),
         .CW  (CW),
         .IDX (k)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .cnt     (cnt_ff),
         .limit   (limit),
         .strike  (strike_ff),
         .left_v  ((k == 0) ? dval_ff : cv[(k == 0) ? 0 : k-1]),
         .left_f  ((k == 0) ? dsat_ff : cf[(k == 0) ? 0 : k-1]),
         .right_v (cv[k+1]),
         .right_f (cf[k+1]),
         .v       (cv[k]),
         .f       (cf[k])
      );
   end

   assign req_ready        = (state_ff == btfo_pkg::ST_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_option_price = out_price_ff;
   assign rsp_overflow     = out_ovf_ff;
endmodule
`default_nettype wire

// File: rtl/btfo_checker.sv
// Port-level checks of the option pricer and their binding to the top level.
`default_nettype none
`include "binomial_tree_futures_option_assert.svh"
module btfo_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_option_price,
   input wire        rsp_overflow
);
   `BTFO_CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_option_price))
   `BTFO_CHK_NEXT(a_rsp_hold_ovf, rsp_valid && !rsp_ready, $stable(rsp_overflow))
   `BTFO_CHK_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
   `BTFO_CHK_NEXT(a_no_instant_result, req_valid && req_ready && !rsp_valid, !rsp_valid)
   `BTFO_CHK_RST(a_reset_idle, req_ready && !rsp_valid)
endmodule

bind binomial_tree_futures_option btfo_checker u_btfo_checker (.*);
`default_nettype wire
